// ----- rtl/tilt_angle_averager_top_macros.svh -----
// assertion macros for the tilt angle averager
`ifndef TILT_ANGLE_AVERAGER_TOP_MACROS_SVH
`define TILT_ANGLE_AVERAGER_TOP_MACROS_SVH

// implication checked at every clock outside reset
`define TAA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tilt averager check failed");

// condition checked in the cycle after the antecedent
`define TAA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tilt averager check failed");

`endif

// ----- rtl/taa_pkg.sv -----
package taa_pkg;

  localparam int AVERAGE_COUNT = 10;
  localparam int ANGLE_FRACTION_BITS = 8;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN = 24;
  localparam int SUM_WIDTH = 21;
  localparam int DEV_WIDTH = 18;
  localparam int CORDIC_WIDTH = 30;
  localparam int Z_WIDTH = 26;
  localparam logic [30:0] GAIN_Q30 = 31'd1074286442;

  localparam logic [15:0] X_OFFSET_RESET = 16'sd436;
  localparam logic [15:0] Y_OFFSET_RESET = -16'sd1339;
  localparam logic [15:0] Z_OFFSET_RESET = 16'sd434;
  localparam logic [16:0] REF_XZ_RESET = 17'sd23528;
  localparam logic [16:0] REF_XY_RESET = 17'sd23069;
  localparam logic [9:0] LEVEL_BAND_RESET = 10'd18;

  localparam logic [2:0] REG_X_OFFSET = 3'd0;
  localparam logic [2:0] REG_Y_OFFSET = 3'd1;
  localparam logic [2:0] REG_Z_OFFSET = 3'd2;
  localparam logic [2:0] REG_REF_XZ = 3'd3;
  localparam logic [2:0] REG_REF_XY = 3'd4;
  localparam logic [2:0] REG_LEVEL_BAND = 3'd5;

  localparam logic [1:0] CLASS_NEGATIVE = 2'd0;
  localparam logic [1:0] CLASS_LEVEL = 2'd1;
  localparam logic [1:0] CLASS_POSITIVE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD_XZ, ST_ITER_XZ, ST_GAIN_XZ, ST_ROUND_XZ,
    ST_LOAD_XY, ST_ITER_XY, ST_GAIN_XY, ST_ROUND_XY,
    ST_DEV_SUB, ST_DEV_MUL, ST_DEV_FIX, ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_xz;
    logic load_xy;
    logic iterate;
    logic gain;
    logic acc_xz;
    logic acc_xy;
    logic dev_sub;
    logic dev_mul;
    logic dev_fix;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic iter_done;
    logic last_sample;
    logic out_busy;
  } status_t;

  function automatic logic signed [25:0] atan_deg_q16(input logic [4:0] i);
    logic signed [25:0] r;
    begin
      unique case (i)
        5'd0: r = 26'sd2949120;  5'd1: r = 26'sd1740967;
        5'd2: r = 26'sd919879;   5'd3: r = 26'sd466945;
        5'd4: r = 26'sd234379;   5'd5: r = 26'sd117304;
        5'd6: r = 26'sd58666;    5'd7: r = 26'sd29335;
        5'd8: r = 26'sd14668;    5'd9: r = 26'sd7334;
        5'd10: r = 26'sd3667;    5'd11: r = 26'sd1833;
        5'd12: r = 26'sd917;     5'd13: r = 26'sd458;
        5'd14: r = 26'sd229;     5'd15: r = 26'sd115;
        5'd16: r = 26'sd57;      5'd17: r = 26'sd29;
        5'd18: r = 26'sd14;      5'd19: r = 26'sd7;
        5'd20: r = 26'sd4;       5'd21: r = 26'sd2;
        5'd22: r = 26'sd1;
        default: r = 26'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- rtl/taa_ctrl.sv -----
module taa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  taa_pkg::status_t  status,
  output taa_pkg::cmd_t     cmd
);

  taa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= taa_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      taa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = taa_pkg::ST_LOAD_XZ;
        end
      end
      taa_pkg::ST_LOAD_XZ: begin
        cmd.load_xz = 1'b1;
        state_next = taa_pkg::ST_ITER_XZ;
      end
      taa_pkg::ST_ITER_XZ: begin
        cmd.iterate = 1'b1;
        if (status.iter_done) state_next = taa_pkg::ST_GAIN_XZ;
      end
      taa_pkg::ST_GAIN_XZ: begin
        cmd.gain = 1'b1;
        state_next = taa_pkg::ST_ROUND_XZ;
      end
      taa_pkg::ST_ROUND_XZ: begin
        cmd.acc_xz = 1'b1;
        state_next = taa_pkg::ST_LOAD_XY;
      end
      taa_pkg::ST_LOAD_XY: begin
        cmd.load_xy = 1'b1;
        state_next = taa_pkg::ST_ITER_XY;
      end
      taa_pkg::ST_ITER_XY: begin
        cmd.iterate = 1'b1;
        if (status.iter_done) state_next = taa_pkg::ST_GAIN_XY;
      end
      taa_pkg::ST_GAIN_XY: begin
        cmd.gain = 1'b1;
        state_next = taa_pkg::ST_ROUND_XY;
      end
      taa_pkg::ST_ROUND_XY: begin
        cmd.acc_xy = 1'b1;
        state_next = status.last_sample ? taa_pkg::ST_DEV_SUB : taa_pkg::ST_IDLE;
      end
      taa_pkg::ST_DEV_SUB: begin
        cmd.dev_sub = 1'b1;
        state_next = taa_pkg::ST_DEV_MUL;
      end
      taa_pkg::ST_DEV_MUL: begin
        cmd.dev_mul = 1'b1;
        state_next = taa_pkg::ST_DEV_FIX;
      end
      taa_pkg::ST_DEV_FIX: begin
        cmd.dev_fix = 1'b1;
        state_next = taa_pkg::ST_OUT;
      end
      taa_pkg::ST_OUT: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          state_next = taa_pkg::ST_IDLE;
        end
      end
      default: state_next = taa_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/taa_datapath.sv -----
module taa_datapath #(
  parameter int AverageCount = taa_pkg::AVERAGE_COUNT,
  parameter int AngleFractionBits = taa_pkg::ANGLE_FRACTION_BITS,
  parameter int CordicSteps = taa_pkg::CORDIC_STEPS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [47:0]       in_word,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [16:0]       cfg_data,
  input  taa_pkg::cmd_t     cmd,
  output taa_pkg::status_t  status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [71:0]       out_word
);

  localparam int CW = taa_pkg::CORDIC_WIDTH;
  localparam int ZW = taa_pkg::Z_WIDTH;
  localparam int SW = taa_pkg::SUM_WIDTH;
  localparam int DW = taa_pkg::DEV_WIDTH;
  localparam int Steps = (CordicSteps < taa_pkg::TABLE_LEN) ? CordicSteps
                                                            : taa_pkg::TABLE_LEN;
  localparam int Shift = 46 - AngleFractionBits;
  // reciprocal for divide by average count
  localparam int RecipBits = 26;
  localparam longint Recip = ((64'd1 << RecipBits) + AverageCount - 1) / AverageCount;
  localparam int DivW = 24;

  logic signed [15:0] x_offset, y_offset, z_offset;
  logic signed [16:0] ref_xz, ref_xy;
  logic [9:0] level_band;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= taa_pkg::X_OFFSET_RESET;
      y_offset <= taa_pkg::Y_OFFSET_RESET;
      z_offset <= taa_pkg::Z_OFFSET_RESET;
      ref_xz <= taa_pkg::REF_XZ_RESET;
      ref_xy <= taa_pkg::REF_XY_RESET;
      level_band <= taa_pkg::LEVEL_BAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        taa_pkg::REG_X_OFFSET: x_offset <= cfg_data[15:0];
        taa_pkg::REG_Y_OFFSET: y_offset <= cfg_data[15:0];
        taa_pkg::REG_Z_OFFSET: z_offset <= cfg_data[15:0];
        taa_pkg::REG_REF_XZ: ref_xz <= cfg_data;
        taa_pkg::REG_REF_XY: ref_xy <= cfg_data;
        taa_pkg::REG_LEVEL_BAND: level_band <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // axis decode
  logic signed [17:0] xv, yv, zv;

  function automatic logic signed [17:0] axis(input logic [7:0] lo, input logic [7:0] hi,
                                              input logic signed [15:0] off);
    logic signed [11:0] c;
    begin
      c = {hi, lo[7:4]};
      return {{2{c[11]}}, c, 4'b0} + 18'(off);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xv <= axis(in_word[7:0], in_word[15:8], x_offset);
      yv <= axis(in_word[23:16], in_word[31:24], y_offset);
      zv <= axis(in_word[39:32], in_word[47:40], z_offset);
    end
  end

  // shared cordic
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic [4:0] step;
  logic czero;
  logic signed [CW-1:0] xs, ys;
  logic signed [17:0] lnum, lden;

  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign lnum = xv;
  assign lden = cmd.load_xz ? zv : yv;
  assign status.iter_done = (step == 5'(Steps - 1));

  always_ff @(posedge clk) begin
    if (cmd.load_xz || cmd.load_xy) begin
      step <= '0;
      czero <= (lnum == 0 && lden == 0);
      if (lnum == 0 && lden == 0) begin
        cx <= '0;
        cy <= '0;
        cz <= '0;
      end else if (lden < 0) begin
        cx <= -{{(CW-26){lden[17]}}, lden, 8'b0};
        cy <= -{{(CW-26){lnum[17]}}, lnum, 8'b0};
        cz <= (lnum >= 0) ? ZW'(180 * 65536) : -ZW'(180 * 65536);
      end else begin
        cx <= {{(CW-26){lden[17]}}, lden, 8'b0};
        cy <= {{(CW-26){lnum[17]}}, lnum, 8'b0};
        cz <= '0;
      end
    end else if (cmd.iterate) begin
      step <= step + 5'd1;
      // zero vector keeps a zero angle
      if (czero) begin
        cz <= '0;
      end else if (!cy[CW-1]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + taa_pkg::atan_deg_q16(step);
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - taa_pkg::atan_deg_q16(step);
      end
    end
  end

  // gain and round, half away from zero
  logic [ZW-2:0] zmag;
  logic [56:0] prod;
  logic zneg;
  logic signed [SW-1:0] angle;
  logic [56:0] rnd;

  assign zmag = cz[ZW-1] ? (ZW-1)'(-cz) : cz[ZW-2:0];

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      prod <= 57'(zmag) * 57'(taa_pkg::GAIN_Q30);
      zneg <= cz[ZW-1];
    end
  end

  assign rnd = (prod + (57'd1 << (Shift - 1))) >> Shift;
  assign angle = zneg ? -SW'(rnd) : SW'(rnd);

  logic signed [SW-1:0] xz_sum, xy_sum;
  logic [3:0] count;

  assign status.last_sample = (count == 4'(AverageCount));

  always_ff @(posedge clk) begin
    if (rst) begin
      xz_sum <= '0;
      xy_sum <= '0;
      count <= '0;
    end else if (cmd.acc_xz) begin
      xz_sum <= xz_sum + angle;
      count <= count + 4'd1;
    end else if (cmd.acc_xy) begin
      xy_sum <= xy_sum + angle;
    end else if (cmd.dev_sub) begin
      xz_sum <= '0;
      xy_sum <= '0;
      count <= '0;
    end
  end

  // deviation: magnitude divided by reciprocal multiply with a correction
  logic [DivW-1:0] mxz, mxy;
  logic nxz, nxy;
  logic [DivW+RecipBits-1:0] pxz, pxy;
  logic signed [DivW:0] dxz_full, dxy_full;
  logic signed [DivW:0] sub_xz, sub_xy;

  assign sub_xz = (DivW+1)'(xz_sum) - (DivW+1)'(AverageCount) * (DivW+1)'(ref_xz);
  assign sub_xy = (DivW+1)'(xy_sum) - (DivW+1)'(AverageCount) * (DivW+1)'(ref_xy);

  always_ff @(posedge clk) begin
    if (cmd.dev_sub) begin
      nxz <= sub_xz[DivW];
      nxy <= sub_xy[DivW];
      mxz <= (sub_xz[DivW] ? DivW'(-sub_xz) : DivW'(sub_xz)) + DivW'(AverageCount / 2);
      mxy <= (sub_xy[DivW] ? DivW'(-sub_xy) : DivW'(sub_xy)) + DivW'(AverageCount / 2);
    end
    if (cmd.dev_mul) begin
      pxz <= (DivW+RecipBits)'(mxz) * (DivW+RecipBits)'(Recip);
      pxy <= (DivW+RecipBits)'(mxy) * (DivW+RecipBits)'(Recip);
    end
  end

  function automatic logic [DivW-1:0] fixq(input logic [DivW+RecipBits-1:0] p,
                                           input logic [DivW-1:0] m);
    logic [DivW-1:0] q;
    begin
      q = p[DivW+RecipBits-1:RecipBits];
      if (DivW'(q * DivW'(AverageCount)) > m) q = q - DivW'(1);
      return q;
    end
  endfunction

  logic [DivW-1:0] qxz, qxy;
  assign qxz = fixq(pxz, mxz);
  assign qxy = fixq(pxy, mxy);
  assign dxz_full = nxz ? -(DivW+1)'(qxz) : (DivW+1)'(qxz);
  assign dxy_full = nxy ? -(DivW+1)'(qxy) : (DivW+1)'(qxy);

  logic signed [DW-1:0] dxz, dxy;
  always_ff @(posedge clk) begin
    if (cmd.dev_fix) begin
      dxz <= dxz_full[DW-1:0];
      dxy <= dxy_full[DW-1:0];
    end
  end

  logic [1:0] cls;
  logic signed [DW-1:0] band;
  logic [DW-1:0] axz, axy;
  assign band = DW'(level_band);
  assign axz = dxz[DW-1] ? DW'(-dxz) : dxz;
  assign axy = dxy[DW-1] ? DW'(-dxy) : dxy;

  always_comb begin
    if (dxz < -band) cls = taa_pkg::CLASS_NEGATIVE;
    else if (dxz > band) cls = taa_pkg::CLASS_POSITIVE;
    else cls = taa_pkg::CLASS_LEVEL;
  end

  // output register
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word <= {axy[15:0], ~dxy[DW-1], axz[15:0], ~dxz[DW-1], dxy, dxz, cls};
    end
  end

endmodule

// ----- rtl/tilt_angle_averager_top.sv -----
// Tilt angle averager. Each accepted word is one accelerometer sample (six raw
// bytes); a shared CORDIC forms atan2(x,z) then atan2(x,y), one step per cycle,
// and a new sample is taken only once the previous one is through. Every
// AVERAGE_COUNT-th sample then passes the deviation states and, when the output
// is free, yields one result word of averaged deviations, class and magnitudes;
// other samples yield none. Configuration writes take effect at once.
module tilt_angle_averager_top #(
  parameter int AverageCount = taa_pkg::AVERAGE_COUNT,
  parameter int AngleFractionBits = taa_pkg::ANGLE_FRACTION_BITS,
  parameter int CordicSteps = taa_pkg::CORDIC_STEPS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tilt_class, xz_deviation, xy_deviation, xz_nonnegative, xz_magnitude,
  // xy_nonnegative, xy_magnitude
  output logic [71:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  taa_pkg::cmd_t cmd;
  taa_pkg::status_t status;

  taa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .status(status), .cmd(cmd)
  );

  taa_datapath #(
    .AverageCount(AverageCount), .AngleFractionBits(AngleFractionBits),
    .CordicSteps(CordicSteps)
  ) u_dp (
    .clk(clk), .rst(rst), .in_word(s_tdata), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .status(status),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_word(m_tdata)
  );

endmodule

// ----- rtl/taa_checker.sv -----
`include "tilt_angle_averager_top_macros.svh"

module taa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  `TAA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `TAA_ASSERT_IMP(a_class_code, m_tvalid, m_tdata[1:0] != 2'd3)
  `TAA_ASSERT_IMP(a_xz_flag, m_tvalid, m_tdata[38] == !m_tdata[19])
  `TAA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind tilt_angle_averager_top taa_checker u_taa_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
